>>> src/alis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alis_pkg
// Shared types and constants of the sequential array list core.
// ----------------------------------------------------------------------------
package alis_pkg;

	localparam int CAPACITY = 128;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int TAG_W    = 32;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_LINEAR = 2'd2,
		KIND_BINARY = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_FAIL = 2'd1,
		STAT_MISS = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_WR,
		ST_INS_PUT,
		ST_SCAN,
		ST_DEL_SHIFT,
		ST_BIN_RD,
		ST_BIN_CMP,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [KEY_W-1:0] key;
	} entry_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [TAG_W-1:0] found_tag;
		logic [6:0]       index;
		status_t          status;
	} result_t;

	localparam int RES_W = $bits(result_t);

endpackage

>>> src/array_list_insert_delete_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_insert_delete_search_core
// Bounded list of keyed records in one single-port-read, single-port-write RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one item per operation. s_tuser carries the kind
//   (insert, delete by key, linear search, binary search); s_tdata carries
//   key, position and tag. Output stream m_*: exactly one result item per
//   input item, in order, with status, index, found tag and count.
//   One item is worked on at a time. Every record move and every compare
//   costs one RAM access. An insert moves each record from the position up
//   by one place (an append or a failed insert moves none); a delete scans
//   for the key, then moves each record above a match down by one place;
//   a linear search scans up from index 0 to the match or the count; a
//   binary search halves the range on each compare. The next item can be
//   accepted in the cycle after the result is loaded. The single read and
//   write port of the record RAM sets the pace: scans and shifts handle
//   one record per cycle.
//   Reset clears the count and the output valid flag; the RAM is not cleared
//   and never needs to be, since only entries below the count are read.
//   A stalled result waits in the output register while the next item is
//   accepted and worked on; the core then holds its own result until the
//   register frees.
// ----------------------------------------------------------------------------
module array_list_insert_delete_search_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,  // kind
	input  logic [71:0] s_tdata,  // key[31:0], position[39:32], tag[71:40]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // status[1:0], index[8:2], found_tag[40:9],
	                              // count[48:41], zero fill above
);

	localparam int IW = alis_pkg::IDX_W;
	localparam int CW = alis_pkg::CNT_W;

	alis_pkg::state_t  state_q, state_d;
	alis_pkg::entry_t  store_q [alis_pkg::CAPACITY];
	alis_pkg::entry_t  rdata_q;
	alis_pkg::entry_t  wdata;
	alis_pkg::result_t res_q, out_q;

	logic [IW-1:0] raddr, waddr;
	logic          we;

	alis_pkg::kind_t   kind_q;
	logic [31:0]       key_q, tag_q;
	logic [7:0]        pos_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     scan_q;
	logic [IW-1:0]     addr_s1, rd_q, rd_s1, at_q, mid_q;
	logic              vld_s1;
	logic [CW-1:0]     lo_q, hi_q;
	logic              m_valid_q;

	logic              accept, out_free, issue, hit, scan_end, ins_fail;
	logic [CW:0]       mid_sum;
	logic [IW-1:0]     mid;
	logic              bin_eq, bin_less;
	alis_pkg::kind_t   kind_in;
	logic [7:0]        pos_in;

	assign kind_in  = alis_pkg::kind_t'(s_tuser);
	assign pos_in   = s_tdata[39:32];
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign ins_fail = (count_q >= CW'(alis_pkg::CAPACITY)) || ({1'b0, pos_in} > 9'(count_q));
	assign issue    = scan_q < count_q;
	assign hit      = vld_s1 && (rdata_q.key == key_q);
	assign scan_end = !issue && !vld_s1;
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q} - (CW+1)'(1);
	assign mid      = mid_sum[IW:1];
	assign bin_eq   = rdata_q.key == key_q;
	assign bin_less = $signed(rdata_q.key) < $signed(key_q);

	assign s_tready = (state_q == alis_pkg::ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(56 - alis_pkg::RES_W)'(0), out_q};

	// record RAM, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
		rdata_q <= store_q[raddr];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			alis_pkg::ST_IDLE: begin
				if (accept) begin
					case (kind_in)
						alis_pkg::KIND_INSERT: begin
							if (ins_fail)
								state_d = alis_pkg::ST_FIN;
							else if (9'(pos_in) == {1'b0, count_q})
								state_d = alis_pkg::ST_INS_PUT;
							else
								state_d = alis_pkg::ST_INS_RD;
						end
						alis_pkg::KIND_BINARY: state_d = alis_pkg::ST_BIN_RD;
						default:               state_d = alis_pkg::ST_SCAN;
					endcase
				end
			end
			alis_pkg::ST_INS_RD: begin
				if (rd_q == pos_q[IW-1:0])
					state_d = alis_pkg::ST_INS_WR;
			end
			alis_pkg::ST_INS_WR:  state_d = alis_pkg::ST_INS_PUT;
			alis_pkg::ST_INS_PUT: state_d = alis_pkg::ST_FIN;
			alis_pkg::ST_SCAN: begin
				if (hit)
					state_d = (kind_q == alis_pkg::KIND_DELETE) ? alis_pkg::ST_DEL_SHIFT
					                                            : alis_pkg::ST_FIN;
				else if (scan_end)
					state_d = alis_pkg::ST_FIN;
			end
			alis_pkg::ST_DEL_SHIFT: begin
				if (scan_end)
					state_d = alis_pkg::ST_FIN;
			end
			alis_pkg::ST_BIN_RD: begin
				state_d = (lo_q < hi_q) ? alis_pkg::ST_BIN_CMP : alis_pkg::ST_FIN;
			end
			alis_pkg::ST_BIN_CMP: begin
				state_d = bin_eq ? alis_pkg::ST_FIN : alis_pkg::ST_BIN_RD;
			end
			alis_pkg::ST_FIN: begin
				if (out_free)
					state_d = alis_pkg::ST_IDLE;
			end
			default: state_d = alis_pkg::ST_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		raddr = '0;
		we    = 1'b0;
		waddr = '0;
		wdata = rdata_q;
		unique case (state_q)
			alis_pkg::ST_INS_RD: begin
				raddr = rd_q;
				we    = vld_s1;
				waddr = rd_s1 + IW'(1);
			end
			alis_pkg::ST_INS_WR: begin
				we    = 1'b1;
				waddr = rd_s1 + IW'(1);
			end
			alis_pkg::ST_INS_PUT: begin
				we        = 1'b1;
				waddr     = pos_q[IW-1:0];
				wdata.key = key_q;
				wdata.tag = tag_q;
			end
			alis_pkg::ST_SCAN: begin
				raddr = scan_q[IW-1:0];
			end
			alis_pkg::ST_DEL_SHIFT: begin
				raddr = scan_q[IW-1:0];
				we    = vld_s1;
				waddr = addr_s1 - IW'(1);
			end
			alis_pkg::ST_BIN_RD: begin
				raddr = mid;
			end
			default: begin
				raddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= alis_pkg::ST_IDLE;
			count_q   <= '0;
			vld_s1    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				alis_pkg::ST_INS_RD:    vld_s1 <= 1'b1;
				alis_pkg::ST_SCAN:      vld_s1 <= issue && !hit;
				alis_pkg::ST_DEL_SHIFT: vld_s1 <= issue;
				default:                vld_s1 <= 1'b0;
			endcase
			if (state_q == alis_pkg::ST_INS_PUT)
				count_q <= count_q + CW'(1);
			else if (state_q == alis_pkg::ST_DEL_SHIFT && scan_end)
				count_q <= count_q - CW'(1);
			if (state_q == alis_pkg::ST_FIN && out_free)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			alis_pkg::ST_IDLE: begin
				if (accept) begin
					kind_q <= kind_in;
					key_q  <= s_tdata[31:0];
					pos_q  <= pos_in;
					tag_q  <= s_tdata[71:40];
					scan_q <= '0;
					rd_q   <= IW'(count_q - CW'(1));
					lo_q   <= '0;
					hi_q   <= count_q;
					res_q  <= '{count: count_q, found_tag: '0, index: '0,
					            status: alis_pkg::STAT_FAIL};
				end
			end
			alis_pkg::ST_INS_RD: begin
				rd_s1 <= rd_q;
				rd_q  <= rd_q - IW'(1);
			end
			alis_pkg::ST_INS_PUT: begin
				res_q <= '{count: count_q + CW'(1), found_tag: '0, index: '0,
				            status: alis_pkg::STAT_OK};
			end
			alis_pkg::ST_SCAN: begin
				if (hit) begin
					// restart reads just above the match for the shift down
					at_q   <= addr_s1;
					scan_q <= CW'(addr_s1) + CW'(1);
					res_q  <= '{count: count_q, found_tag: rdata_q.tag, index: addr_s1,
					            status: alis_pkg::STAT_OK};
				end else begin
					if (issue) begin
						addr_s1 <= scan_q[IW-1:0];
						scan_q  <= scan_q + CW'(1);
					end
					if (scan_end)
						res_q <= '{count: count_q, found_tag: '0, index: '0,
						            status: alis_pkg::STAT_MISS};
				end
			end
			alis_pkg::ST_DEL_SHIFT: begin
				if (issue) begin
					addr_s1 <= scan_q[IW-1:0];
					scan_q  <= scan_q + CW'(1);
				end
				if (scan_end)
					res_q <= '{count: count_q - CW'(1), found_tag: '0, index: at_q,
					            status: alis_pkg::STAT_OK};
			end
			alis_pkg::ST_BIN_RD: begin
				mid_q <= mid;
				if (lo_q >= hi_q)
					res_q <= '{count: count_q, found_tag: '0, index: '0,
					            status: alis_pkg::STAT_MISS};
			end
			alis_pkg::ST_BIN_CMP: begin
				if (bin_eq)
					res_q <= '{count: count_q, found_tag: rdata_q.tag, index: mid_q,
					            status: alis_pkg::STAT_OK};
				else if (bin_less)
					lo_q <= CW'(mid_q) + CW'(1);
				else
					hi_q <= CW'(mid_q);
			end
			alis_pkg::ST_FIN: begin
				if (out_free)
					out_q <= res_q;
			end
			default: begin
				rd_s1 <= rd_s1;
			end
		endcase
	end

endmodule

>>> src/alis_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alis_checker
// Port-level checks of the array list core, bound to the top level.
// ----------------------------------------------------------------------------
module alis_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one item at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while busy");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[48:41] <= 8'(alis_pkg::CAPACITY))
		else $error("count above capacity");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("undefined status code");

	// failed and missed operations report no index and no tag
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != alis_pkg::STAT_OK) |->
			m_tdata[8:2] == 7'd0 && m_tdata[40:9] == 32'd0)
		else $error("failed result carries index or tag");

endmodule

bind array_list_insert_delete_search_core alis_checker u_alis_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> sim/array_list_insert_delete_search_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_insert_delete_search_core_tb
// Self-checking bench for the sequential array list core. It mirrors the list
// in a behavioral copy, sends inserts, deletes and both kinds of search with
// random idling on both streams, and checks each result field by field.
// ----------------------------------------------------------------------------
module array_list_insert_delete_search_core_tb;
	import alis_pkg::*;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [1:0]  s_tuser  = '0;  // kind
	logic [71:0] s_tdata  = '0;  // key[31:0], position[39:32], tag[71:40]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;        // status[1:0], index[8:2], found_tag[40:9], count[48:41]

	array_list_insert_delete_search_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Mirror of the list contents
	logic [KEY_W-1:0] list_key [CAPACITY];
	logic [TAG_W-1:0] list_tag [CAPACITY];
	int unsigned      list_len = 0;

	result_t     pending_results[$];
	int unsigned mismatch_count = 0;
	bit          idle_en        = 1'b1;
	int unsigned stall_left     = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit scan_for_key(input logic [KEY_W-1:0] key, output int at);
		int i;
		at = 0;
		for (i = 0; i < list_len; i++) begin
			if (list_key[i] == key) begin
				at = i;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic bit halve_for_key(input logic [KEY_W-1:0] key, output int at);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = list_len;
		at = 0;
		while (lo < hi) begin
			mid = (lo + hi - 1) / 2;
			if (list_key[mid] == key) begin
				at = mid;
				return 1'b1;
			end
			if ($signed(list_key[mid]) < $signed(key))
				lo = mid + 1;
			else
				hi = mid;
		end
		return 1'b0;
	endfunction

	// Apply one operation to the mirror and return the result it should give
	function automatic result_t apply_op(input kind_t kind, input logic [KEY_W-1:0] key,
			input logic [7:0] pos, input logic [TAG_W-1:0] tag);
		result_t r;
		int      at;
		int      i;
		bit      hit;
		r = '0;
		r.status = STAT_OK;
		case (kind)
			KIND_INSERT: begin
				if (list_len >= CAPACITY || pos > list_len) begin
					r.status = STAT_FAIL;
				end else begin
					for (i = list_len; i > pos; i--) begin
						list_key[i] = list_key[i-1];
						list_tag[i] = list_tag[i-1];
					end
					list_key[pos] = key;
					list_tag[pos] = tag;
					list_len++;
				end
			end
			KIND_DELETE: begin
				if (!scan_for_key(key, at)) begin
					r.status = STAT_MISS;
				end else begin
					for (i = at; i + 1 < list_len; i++) begin
						list_key[i] = list_key[i+1];
						list_tag[i] = list_tag[i+1];
					end
					list_len--;
					r.index = at[6:0];
				end
			end
			default: begin
				if (kind == KIND_LINEAR)
					hit = scan_for_key(key, at);
				else
					hit = halve_for_key(key, at);
				if (!hit) begin
					r.status = STAT_MISS;
				end else begin
					r.index     = at[6:0];
					r.found_tag = list_tag[at];
				end
			end
		endcase
		r.count = list_len[CNT_W-1:0];
		return r;
	endfunction

	// Hold valid across back-to-back items; drop it only for an idle burst
	task automatic send_op(input kind_t kind, input logic [KEY_W-1:0] key,
			input logic [7:0] pos, input logic [TAG_W-1:0] tag);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {tag, pos, key};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(apply_op(kind, key, pos, tag));
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		int unsigned roll;
		roll = $urandom_range(0, 3);
		if (list_len != 0 && roll < 2)
			return list_key[$urandom_range(0, list_len - 1)];
		if (roll == 2)
			return $urandom_range(0, 15) - 8;
		return $urandom();
	endfunction

	function automatic logic [KEY_W-1:0] pick_sorted_key();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return 32'h8000_0000;
		if (roll == 1)
			return 32'h7fff_ffff;
		if (roll < 4)
			return $urandom();
		return $urandom_range(0, 60) - 30;
	endfunction

	// Slot after every key not greater than the new one; keeps the list sorted
	function automatic logic [7:0] sorted_slot(input logic [KEY_W-1:0] key);
		int i;
		i = 0;
		while (i < list_len && $signed(list_key[i]) <= $signed(key))
			i++;
		return i[7:0];
	endfunction

	task automatic random_op();
		kind_t       kind;
		logic [7:0]  pos;
		int unsigned roll;
		int unsigned ins_pct;
		ins_pct = (list_len < 64) ? 45 : 25;
		roll = $urandom_range(0, 99);
		if (roll < ins_pct)
			kind = KIND_INSERT;
		else if (roll < ins_pct + 25)
			kind = KIND_DELETE;
		else if (roll < ins_pct + 45)
			kind = KIND_LINEAR;
		else
			kind = KIND_BINARY;
		if ($urandom_range(0, 9) == 0)
			pos = 8'($urandom_range(list_len + 1, 255));
		else
			pos = 8'($urandom_range(0, list_len));
		send_op(kind, pick_key(), pos, $urandom());
	endtask

	task automatic test_empty_list();
		send_op(KIND_DELETE, 32'h0000_0000, 8'd0, 32'h0);
		send_op(KIND_LINEAR, 32'hffff_ffff, 8'd0, 32'h0);
		send_op(KIND_BINARY, 32'h8000_0000, 8'd0, 32'h0);
		send_op(KIND_INSERT, 32'h1234_5678, 8'd1, 32'hdead_beef);
		send_op(KIND_INSERT, 32'h1234_5678, 8'hff, 32'hdead_beef);
	endtask

	task automatic test_directed_ops();
		// build min, -1, 0, 0, max in sorted order through head, tail and middle inserts
		send_op(KIND_INSERT, 32'h8000_0000, 8'd0, 32'h0000_0000);
		send_op(KIND_INSERT, 32'h7fff_ffff, 8'd1, 32'hffff_ffff);
		send_op(KIND_INSERT, 32'h0000_0000, 8'd1, 32'ha5a5_a5a5);
		send_op(KIND_INSERT, 32'hffff_ffff, 8'd1, 32'h5a5a_5a5a);
		send_op(KIND_INSERT, 32'h0000_0001, 8'd5, 32'h1111_1111);
		send_op(KIND_INSERT, 32'h0000_0000, 8'd3, 32'h2222_2222);
		send_op(KIND_LINEAR, 32'h0000_0000, 8'd0, 32'h0);
		send_op(KIND_BINARY, 32'h0000_0000, 8'd0, 32'h0);
		send_op(KIND_BINARY, 32'h7fff_ffff, 8'd0, 32'h0);
		send_op(KIND_BINARY, 32'h8000_0000, 8'd0, 32'h0);
		send_op(KIND_BINARY, 32'h0000_0005, 8'd0, 32'h0);
		send_op(KIND_LINEAR, 32'h0000_0005, 8'd0, 32'h0);
		send_op(KIND_LINEAR, 32'hffff_ffff, 8'd0, 32'h0);
		send_op(KIND_DELETE, 32'h0000_0000, 8'd0, 32'h0);
		send_op(KIND_DELETE, 32'h7fff_ffff, 8'd0, 32'h0);
		send_op(KIND_DELETE, 32'h8000_0000, 8'd0, 32'h0);
		send_op(KIND_DELETE, 32'h0000_0042, 8'd0, 32'h0);
	endtask

	task automatic test_fill_to_capacity();
		while (list_len < CAPACITY)
			send_op(KIND_INSERT, $urandom(), 8'($urandom_range(0, list_len)), $urandom());
		send_op(KIND_INSERT, $urandom(), 8'd0, $urandom());
		send_op(KIND_INSERT, $urandom(), 8'd128, $urandom());
		send_op(KIND_INSERT, $urandom(), 8'hff, $urandom());
		// full walks: last entry and a miss
		send_op(KIND_LINEAR, list_key[CAPACITY-1], 8'($urandom()), $urandom());
		send_op(KIND_LINEAR, ~list_key[0] ^ list_key[1], 8'($urandom()), $urandom());
		repeat (16) begin
			send_op(KIND_BINARY, pick_key(), 8'($urandom()), $urandom());
			send_op(KIND_LINEAR, pick_key(), 8'($urandom()), $urandom());
		end
		while (list_len != 0)
			send_op(KIND_DELETE, list_key[$urandom_range(0, list_len - 1)], 8'($urandom()),
				$urandom());
	endtask

	task automatic test_sorted_search();
		logic [KEY_W-1:0] key;
		int unsigned      roll;
		repeat (48) begin
			key = pick_sorted_key();
			send_op(KIND_INSERT, key, sorted_slot(key), $urandom());
		end
		repeat (80)
			send_op(KIND_BINARY, pick_key(), 8'($urandom()), $urandom());
		repeat (100) begin
			roll = $urandom_range(0, 3);
			if (roll == 0) begin
				key = pick_sorted_key();
				send_op(KIND_INSERT, key, sorted_slot(key), $urandom());
			end else if (roll == 1) begin
				send_op(KIND_DELETE, pick_key(), 8'($urandom()), $urandom());
			end else begin
				send_op(roll == 2 ? KIND_BINARY : KIND_LINEAR, pick_key(), 8'($urandom()),
					$urandom());
			end
		end
	endtask

	task automatic test_random_mix();
		repeat (450) random_op();
	endtask

	task automatic test_back_to_back();
		idle_en = 1'b0;
		repeat (150) random_op();
	endtask

	// Random stall bursts on the result stream while idling is enabled
	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 16);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[RES_W-1:0];
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: status %0d index %0d tag %h count %0d",
						got.status, got.index, got.found_tag, got.count);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.index !== want.index ||
						got.found_tag !== want.found_tag || got.count !== want.count) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$write("mismatch: expected status %0d index %0d tag %h count %0d,",
							want.status, want.index, want.found_tag, want.count);
						$display(" got status %0d index %0d tag %h count %0d",
							got.status, got.index, got.found_tag, got.count);
					end
				end
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_directed_ops();
		test_fill_to_capacity();
		test_sorted_search();
		test_random_mix();
		test_back_to_back();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		// allow a stray late result to show up
		repeat (150) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("array_list_insert_delete_search_core test passed");
		else
			$display("array_list_insert_delete_search_core test failed");
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("array_list_insert_delete_search_core test failed");
		$finish;
	end

endmodule
